FILE: src/eqa_pkg.sv
`default_nettype none
package eqa_pkg;

  // CORDIC sizing
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = 5;
  localparam int CW = 52;
  localparam int ZW = 34;

  // root term and divider sizing
  localparam int HW = 35;
  localparam int SW = 38;
  localparam int DW = 38;
  localparam int QW = 64;
  localparam int RW = 32;
  localparam int SRW = 34;

  localparam logic signed [ZW-1:0] PI_Q29 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] HALF_PI_Q29 = 34'sd843314857;
  localparam logic signed [ZW-1:0] TWO_PI_Q29 = 34'sd3373259426;
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cst_t;

  typedef struct packed {
    logic [SW-1:0] dvs;
    logic [DW-1:0] rem;
    logic [QW-1:0] q;
  } dst_t;

  typedef struct packed {
    logic [QW-1:0] n;
    logic [SRW-1:0] rem;
    logic [RW-1:0] root;
  } sst_t;

  // sideband through the CORDIC row
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [33:0] ab;
    logic zero;
    logic [32:0] hdir;
    logic signed [ZW-1:0] zdir;
  } side_c_t;

  // sideband through gain and sum stages
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [33:0] ab;
    logic zero;
    logic [32:0] hdir;
    logic signed [ZW-1:0] theta;
  } side_g_t;

  // sideband through divider and root rows
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [ZW-1:0] theta;
    logic bad;
  } side_d_t;

  // arctangent of 2^-i in Q3.29, rounded
  function automatic logic signed [ZW-1:0] atan_q29(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 34'sd421657428;
      5'd1: r = 34'sd248918915;
      5'd2: r = 34'sd131521918;
      5'd3: r = 34'sd66762579;
      5'd4: r = 34'sd33510843;
      5'd5: r = 34'sd16771758;
      5'd6: r = 34'sd8387925;
      5'd7: r = 34'sd4194219;
      5'd8: r = 34'sd2097141;
      5'd9: r = 34'sd1048575;
      5'd10: r = 34'sd524288;
      5'd11: r = 34'sd262144;
      5'd12: r = 34'sd131072;
      5'd13: r = 34'sd65536;
      5'd14: r = 34'sd32768;
      5'd15: r = 34'sd16384;
      5'd16: r = 34'sd8192;
      5'd17: r = 34'sd4096;
      5'd18: r = 34'sd2048;
      5'd19: r = 34'sd1024;
      5'd20: r = 34'sd512;
      5'd21: r = 34'sd256;
      5'd22: r = 34'sd128;
      5'd23: r = 34'sd64;
      5'd24: r = 34'sd32;
      5'd25: r = 34'sd16;
      5'd26: r = 34'sd8;
      5'd27: r = 34'sd4;
      5'd28: r = 34'sd2;
      5'd29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/eqa_cordic_cell.sv
`default_nettype none
module eqa_cordic_cell (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [eqa_pkg::STEP_W-1:0] step,
  input  wire eqa_pkg::cst_t din,
  output eqa_pkg::cst_t dout
);
  import eqa_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  cst_t nxt;

  // one vectoring micro-rotation, floor shifts
  always_comb begin
    dx = din.y >>> step;
    dy = din.x >>> step;
    if (!din.y[CW-1]) begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + atan_q29(step);
    end else begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - atan_q29(step);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire

FILE: src/eqa_div_cell.sv
`default_nettype none
module eqa_div_cell (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic nbit,
  input  wire eqa_pkg::dst_t din,
  output eqa_pkg::dst_t dout
);
  import eqa_pkg::*;

  logic [DW:0] t;
  logic [DW:0] d;
  dst_t nxt;

  // one restoring quotient bit
  always_comb begin
    t = {din.rem, nbit};
    d = {{(DW + 1 - SW){1'b0}}, din.dvs};
    nxt.dvs = din.dvs;
    if (t >= d) begin
      nxt.rem = DW'(t - d);
      nxt.q = {din.q[QW-2:0], 1'b1};
    end else begin
      nxt.rem = DW'(t);
      nxt.q = {din.q[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire

FILE: src/eqa_sqrt_cell.sv
`default_nettype none
module eqa_sqrt_cell (
  input  wire logic clk,
  input  wire logic en,
  input  wire eqa_pkg::sst_t din,
  output eqa_pkg::sst_t dout
);
  import eqa_pkg::*;

  logic [SRW+1:0] t;
  logic [SRW+1:0] trial;
  sst_t nxt;

  // one root digit from the top two radicand bits
  always_comb begin
    t = {din.rem, din.n[QW-1:QW-2]};
    trial = {2'b00, din.root, 2'b01};
    nxt.n = {din.n[QW-3:0], 2'b00};
    if (t >= trial) begin
      nxt.rem = SRW'(t - trial);
      nxt.root = {din.root[RW-2:0], 1'b1};
    end else begin
      nxt.rem = SRW'(t);
      nxt.root = {din.root[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire

FILE: src/ellipse_quadratic_to_axes.sv
`default_nettype none
// Ellipse quadratic form to center, angle and radii. Fully pipelined: one
// ellipse per cycle enters and leaves while no result is held, passing
// an input stage, one CORDIC cell per step, gain, sum and term stages, a
// 64-cell divider row per radius, a 32-cell root row per radius and the
// output register. The whole pipeline holds while a result waits under
// out_stall; in_stall follows that condition in the same cycle.
module ellipse_quadratic_to_axes (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [31:0] center_x,
  input  wire logic signed [31:0] center_y,
  input  wire logic signed [31:0] coef_a,
  input  wire logic signed [31:0] coef_b,
  input  wire logic signed [31:0] coef_c,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] out_center_x,
  output logic signed [31:0] out_center_y,
  output logic signed [31:0] angle,
  output logic [31:0] major_radius,
  output logic [31:0] minor_radius,
  output logic not_ellipse
);
  import eqa_pkg::*;

  localparam int LAT = CORDIC_STEPS + 101;

  logic adv;
  logic in_acc;
  logic [LAT-1:0] vld;

  assign adv = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;
  assign in_acc = in_valid && !in_stall;
  assign out_valid = vld[LAT-1];

  // valid tracking, one bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_acc};
    end
  end

  // input stage: quadrant fold and prescale
  cst_t cst [0:CORDIC_STEPS];
  side_c_t sc [0:CORDIC_STEPS];
  logic signed [32:0] u;
  logic signed [32:0] v;
  logic signed [CW-1:0] ux;
  logic signed [CW-1:0] vx;

  always_comb begin
    u = 33'(coef_a) - 33'(coef_b);
    v = {coef_c, 1'b0};
    ux = CW'(u);
    vx = CW'(v);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (u[32]) begin
        cst[0].x <= (-ux) <<< 16;
        cst[0].y <= (-vx) <<< 16;
        cst[0].z <= v[32] ? -PI_Q29 : PI_Q29;
      end else begin
        cst[0].x <= ux <<< 16;
        cst[0].y <= vx <<< 16;
        cst[0].z <= '0;
      end
      sc[0].cx <= center_x;
      sc[0].cy <= center_y;
      sc[0].ab <= 34'(coef_a) + 34'(coef_b);
      sc[0].zero <= (v == '0);
      sc[0].hdir <= u[32] ? 33'(-u) : 33'(u);
      sc[0].zdir <= u[32] ? PI_Q29 : '0;
    end
  end

  // CORDIC row
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    eqa_cordic_cell u_cell (
      .clk (clk),
      .en  (adv),
      .step(STEP_W'(k)),
      .din (cst[k]),
      .dout(cst[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sc[k+1] <= sc[k];
      end
    end
  end

  // gain stage: partial products of x by 1/K, angle halved toward zero
  logic [CW-1:0] xg;
  logic signed [ZW-1:0] zf;
  logic [57:0] p_hi;
  logic [55:0] p_lo;
  side_g_t sg;
  side_g_t sh;
  logic [HW-1:0] h;

  always_comb begin
    xg = cst[CORDIC_STEPS].x[CW-1] ? '0 : cst[CORDIC_STEPS].x;
    zf = sc[CORDIC_STEPS].zero ? sc[CORDIC_STEPS].zdir : cst[CORDIC_STEPS].z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_hi <= 58'(xg[49:24]) * 58'(INV_GAIN_Q32);
      p_lo <= 56'(xg[23:0]) * 56'(INV_GAIN_Q32);
      sg.cx <= sc[CORDIC_STEPS].cx;
      sg.cy <= sc[CORDIC_STEPS].cy;
      sg.ab <= sc[CORDIC_STEPS].ab;
      sg.zero <= sc[CORDIC_STEPS].zero;
      sg.hdir <= sc[CORDIC_STEPS].hdir;
      sg.theta <= (zf + $signed(ZW'(zf[ZW-1]))) >>> 1;
    end
  end

  // root term h
  logic [58:0] acc;
  assign acc = 59'(p_hi) + 59'(p_lo[55:24]);

  always_ff @(posedge clk) begin
    if (adv) begin
      h <= sg.zero ? HW'(sg.hdir) : acc[58:24];
      sh <= sg;
    end
  end

  // rotated diagonal terms, doubled
  logic signed [SW-1:0] s1;
  logic signed [SW-1:0] s2;
  logic s_bad;

  always_comb begin
    s1 = SW'(sh.ab) + $signed({3'b000, h});
    s2 = SW'(sh.ab) - $signed({3'b000, h});
    s_bad = (s1 <= 0) || (s2 <= 0);
  end

  dst_t ds0 [0:QW];
  dst_t ds1 [0:QW];
  side_d_t sd [0:QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      ds0[0].dvs <= (s1 > 0) ? s1 : SW'(1);
      ds0[0].rem <= '0;
      ds0[0].q <= '0;
      ds1[0].dvs <= (s2 > 0) ? s2 : SW'(1);
      ds1[0].rem <= '0;
      ds1[0].q <= '0;
      sd[0].cx <= sh.cx;
      sd[0].cy <= sh.cy;
      sd[0].theta <= sh.theta;
      sd[0].bad <= s_bad;
    end
  end

  // divider rows: 2^63 / S, numerator has only its top bit set
  for (genvar j = 0; j < QW; j++) begin : g_div
    eqa_div_cell u_div0 (
      .clk (clk),
      .en  (adv),
      .nbit(j == 0),
      .din (ds0[j]),
      .dout(ds0[j+1])
    );
    eqa_div_cell u_div1 (
      .clk (clk),
      .en  (adv),
      .nbit(j == 0),
      .din (ds1[j]),
      .dout(ds1[j+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sd[j+1] <= sd[j];
      end
    end
  end

  // root rows
  sst_t ss0 [0:RW];
  sst_t ss1 [0:RW];
  side_d_t sq [0:RW];

  always_comb begin
    ss0[0].n = ds0[QW].q;
    ss0[0].rem = '0;
    ss0[0].root = '0;
    ss1[0].n = ds1[QW].q;
    ss1[0].rem = '0;
    ss1[0].root = '0;
    sq[0] = sd[QW];
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    eqa_sqrt_cell u_sq0 (
      .clk (clk),
      .en  (adv),
      .din (ss0[j]),
      .dout(ss0[j+1])
    );
    eqa_sqrt_cell u_sq1 (
      .clk (clk),
      .en  (adv),
      .din (ss1[j]),
      .dout(ss1[j+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[j+1] <= sq[j];
      end
    end
  end

  // output stage: saturate, order radii, turn angle on a swap
  logic [31:0] r1;
  logic [31:0] r2;
  logic signed [ZW-1:0] th;

  always_comb begin
    r1 = ss0[RW].root;
    r2 = ss1[RW].root;
    th = sq[RW].theta + HALF_PI_Q29;
    if (th >= PI_Q29) begin
      th = th - TWO_PI_Q29;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_center_x <= sq[RW].cx;
      out_center_y <= sq[RW].cy;
      not_ellipse <= sq[RW].bad;
      if (sq[RW].bad) begin
        major_radius <= '1;
        minor_radius <= '1;
        angle <= sq[RW].theta[31:0];
      end else if (r1 < r2) begin
        major_radius <= r2;
        minor_radius <= r1;
        angle <= th[31:0];
      end else begin
        major_radius <= r1;
        minor_radius <= r2;
        angle <= sq[RW].theta[31:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_ellipse |-> (major_radius == '1) && (minor_radius == '1))
    else $error("radii not saturated on a non-ellipse");
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !not_ellipse |-> major_radius >= minor_radius)
    else $error("major radius below minor radius");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle <= 32'sd1686629713) && (angle >= -32'sd1686629713))
    else $error("angle out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input held without a waiting result");
`endif
endmodule
`default_nettype wire
